/* hdl/adpcm2t_pkg.sv */
// Shared types and constants for the two-tap ADPCM frame decoder.
// Used by the decoder top level, its multiply-accumulate unit and its checker.
package adpcm2t_pkg;

  localparam int FRAME_SAMPLES = 14;
  localparam int FRAC_BITS     = 11;
  localparam int ACC_W         = 34;   // holds nib<<26 plus two 16x16 products
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [3:0] LIMIT_MAX = 4'(FRAME_SAMPLES);
  localparam logic [FRAC_BITS-1:0] ROUND_BIAS = FRAC_BITS'(1024);
  localparam logic signed [15:0] PCM_MIN = 16'sh8000;
  localparam logic signed [15:0] PCM_MAX = 16'sh7fff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_NEW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OLD = 3'd5;

  typedef struct packed {
    logic [63:0] frame_bytes;
    logic [3:0]  sample_limit;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic en;      // update the accumulator
    logic first;   // start from the frame term instead of the accumulator
  } mac_ctrl_t;

endpackage

/* hdl/adpcm_two_tap_frame_decoder.sv */
// Two-tap ADPCM frame decoder top level: config registers, history, sequencer.
// Depends on adpcm2t_pkg and adpcm2t_mac.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_ready | frame_bytes, sample_limit, restart
//  out     | output    | out_valid/out_ready | pcm_sample, last_of_frame
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// Each sample uses the single shared multiplier twice, once per tap (c1*newest,
// then c2*older); a new frame is accepted only once the last one is done.
// A frame with a sample limit of zero is accepted and emits nothing.
// The output register stalls the second tap while a sample waits to be taken.
// rst is synchronous and clears the sequencer, history, output valid and config.
module adpcm_two_tap_frame_decoder (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  adpcm2t_pkg::in_word_t                      in_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output adpcm2t_pkg::out_word_t                     out_data,
  input  logic                                       cfg_we,
  input  logic [adpcm2t_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [adpcm2t_pkg::CFG_DATA_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_TAP1, ST_TAP2} state_t;

  state_t state;

  // configuration
  logic [63:0]        coef_word [4];
  logic signed [15:0] init_newest;
  logic signed [15:0] init_older;

  // per-frame working registers
  logic [55:0]        nibbles;      // current nibble in the top four bits
  logic [3:0]         shift;
  logic signed [15:0] c1;
  logic signed [15:0] c2;
  logic [3:0]         idx;
  logic [3:0]         limit;

  // history
  logic signed [15:0] newest;
  logic signed [15:0] older;

  // accept-side decode
  logic [2:0]         pred;
  logic [63:0]        pair_word;
  logic [3:0]         limit_next;
  logic               accept;

  // shared unit hookup
  adpcm2t_pkg::mac_ctrl_t               mac_ctrl;
  logic signed [adpcm2t_pkg::ACC_W-1:0] base;
  logic signed [15:0]                   mac_coef;
  logic signed [15:0]                   mac_hist;
  logic signed [15:0]                   pcm;
  logic signed [adpcm2t_pkg::ACC_W-adpcm2t_pkg::FRAC_BITS-1:0] nib_term;
  logic                                 slot_free;
  logic                                 is_last;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign is_last   = (idx == limit - 4'd1);

  // predictor pair p uses coefficients 2p and 2p+1
  assign pred      = in_data.frame_bytes[62:60];
  assign pair_word = coef_word[pred[2:1]];

  always_comb begin
    limit_next = (in_data.sample_limit > adpcm2t_pkg::LIMIT_MAX) ?
                 adpcm2t_pkg::LIMIT_MAX : in_data.sample_limit;
  end

  // frame term: signed nibble scaled by 2^(shift+11), plus the rounding bias
  always_comb begin
    nib_term = {{(adpcm2t_pkg::ACC_W-adpcm2t_pkg::FRAC_BITS-4){nibbles[55]}},
                nibbles[55:52]};
    nib_term = nib_term <<< shift;
    base     = {nib_term, adpcm2t_pkg::ROUND_BIAS};
  end

  // first tap loads the accumulator; second tap completes the sample
  always_comb begin
    mac_ctrl.en    = (state == ST_TAP1);
    mac_ctrl.first = (state == ST_TAP1);
    mac_coef       = (state == ST_TAP1) ? c1 : c2;
    mac_hist       = (state == ST_TAP1) ? newest : older;
  end

  adpcm2t_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .base (base),
    .coef (mac_coef),
    .hist (mac_hist),
    .pcm  (pcm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      newest      <= '0;
      older       <= '0;
      init_newest <= '0;
      init_older  <= '0;
      for (int i = 0; i < 4; i++) begin
        coef_word[i] <= '0;
      end
    end else begin
      // config writes; indexes past the last register are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          adpcm2t_pkg::REG_COEF_0:   coef_word[0] <= cfg_data;
          adpcm2t_pkg::REG_COEF_1:   coef_word[1] <= cfg_data;
          adpcm2t_pkg::REG_COEF_2:   coef_word[2] <= cfg_data;
          adpcm2t_pkg::REG_COEF_3:   coef_word[3] <= cfg_data;
          adpcm2t_pkg::REG_INIT_NEW: init_newest  <= 16'(cfg_data);
          adpcm2t_pkg::REG_INIT_OLD: init_older   <= 16'(cfg_data);
          default: ;
        endcase
      end

      // drop the output word once taken, unless the second tap refills it
      if (out_valid && out_ready && (state != ST_TAP2)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            nibbles <= in_data.frame_bytes[55:0];
            shift   <= in_data.frame_bytes[59:56];
            c1      <= pred[0] ? pair_word[31:16] : pair_word[63:48];
            c2      <= pred[0] ? pair_word[15:0]  : pair_word[47:32];
            idx     <= '0;
            limit   <= limit_next;
            // restart applies even when the frame emits nothing
            if (in_data.restart) begin
              newest <= init_newest;
              older  <= init_older;
            end
            if (limit_next != 4'd0) begin
              state <= ST_TAP1;
            end
          end
        end
        ST_TAP1: begin
          state <= ST_TAP2;
        end
        ST_TAP2: begin
          // hold the second tap until the output register is free
          if (slot_free) begin
            out_valid              <= 1'b1;
            out_data.pcm_sample    <= pcm;
            out_data.last_of_frame <= is_last;
            older                  <= newest;
            newest                 <= pcm;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              idx     <= idx + 4'd1;
              nibbles <= {nibbles[51:0], 4'd0};
              state   <= ST_TAP1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/adpcm2t_mac.sv */
// Shared 16x16 multiply-accumulate unit with floor shift and 16-bit clamp.
// Depends on adpcm2t_pkg for widths and the control struct.
module adpcm2t_mac (
  input  logic                                  clk,
  input  adpcm2t_pkg::mac_ctrl_t                ctrl,
  input  logic signed [adpcm2t_pkg::ACC_W-1:0]  base,
  input  logic signed [15:0]                    coef,
  input  logic signed [15:0]                    hist,
  output logic signed [15:0]                    pcm
);

  localparam int SH_W = adpcm2t_pkg::ACC_W - adpcm2t_pkg::FRAC_BITS;

  logic signed [adpcm2t_pkg::ACC_W-1:0] acc;
  logic signed [adpcm2t_pkg::ACC_W-1:0] sum;
  logic signed [31:0]                   prod;
  logic signed [SH_W-1:0]               scaled;

  always_comb begin
    prod   = coef * hist;
    sum    = (ctrl.first ? base : acc) + adpcm2t_pkg::ACC_W'(prod);
    scaled = SH_W'(sum >>> adpcm2t_pkg::FRAC_BITS);
    priority if (scaled < SH_W'(adpcm2t_pkg::PCM_MIN)) begin
      pcm = adpcm2t_pkg::PCM_MIN;
    end else if (scaled > SH_W'(adpcm2t_pkg::PCM_MAX)) begin
      pcm = adpcm2t_pkg::PCM_MAX;
    end else begin
      pcm = 16'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= sum;
    end
  end

endmodule

/* hdl/adpcm2t_checker.sv */
// Port-level checker for the two-tap ADPCM frame decoder, bound to the top level.
// Depends on adpcm2t_pkg and adpcm_two_tap_frame_decoder.
module adpcm2t_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input adpcm2t_pkg::in_word_t                in_data,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input adpcm2t_pkg::out_word_t               out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // a frame that emits samples keeps the input closed while it decodes
  a_busy_after_frame: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.sample_limit != 4'd0) |=> !in_ready)
    else $error("input opened right after accepting a frame");

  // a pending sample that is not the last one means the frame is still in work
  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_frame |-> !in_ready)
    else $error("input open before the last sample of a frame");

endmodule

bind adpcm_two_tap_frame_decoder adpcm2t_checker u_adpcm2t_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
